// File: rtl/core/ps2mpd_pkg.sv
// ============================================================================
// PS/2 mouse packet decoder package
// Shared types, header bit positions and delta helper.
// ============================================================================
package ps2mpd_pkg;

    // Header bit positions
    localparam int unsigned HdrBtnMsb = 2;
    localparam int unsigned HdrSync   = 3;
    localparam int unsigned HdrXSign  = 4;
    localparam int unsigned HdrYSign  = 5;
    localparam int unsigned HdrXOvf   = 6;
    localparam int unsigned HdrYOvf   = 7;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned DeltaW = 9;
    localparam int unsigned DyW    = 10;
    localparam int unsigned BtnW   = 3;

    // Clamp values on overflow: +255 and -255 in 9 bits
    localparam logic signed [DeltaW-1:0] ClampPos = 9'sd255;
    localparam logic signed [DeltaW-1:0] ClampNeg = -9'sd255;

    typedef logic [ByteW-1:0]         byte_t;
    typedef logic signed [DeltaW-1:0] delta_t;
    typedef logic signed [DyW-1:0]    dy_t;
    typedef logic [BtnW-1:0]          btn_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XBYTE  = 2'd1,
        PH_YBYTE  = 2'd2
    } phase_t;

    // Sign-extend a motion byte by its header sign bit, clamp on overflow.
    // A zero value with overflow counts as non-negative.
    function automatic delta_t make_delta(input byte_t raw, input logic neg, input logic ovf);
        delta_t v;
        v = $signed({neg, raw});
        if (ovf)
        begin
            v = neg ? ClampNeg : ClampPos;
        end
        return v;
    endfunction

endpackage

// File: rtl/core/ps2mpd_if.sv
// ============================================================================
// PS/2 mouse packet decoder channels
// Valid/ready channels for raw mouse bytes and decoded packets.
// ============================================================================
interface ps2mpd_byte_if;
    logic                valid;
    logic                ready;
    ps2mpd_pkg::byte_t   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ps2mpd_pkt_if;
    logic                valid;
    logic                ready;
    ps2mpd_pkg::delta_t  dx_motion;
    ps2mpd_pkg::dy_t     dy_motion;
    ps2mpd_pkg::btn_t    button_state;

    modport source (output valid, output dx_motion, output dy_motion,
                    output button_state, input ready);
    modport sink   (input valid, input dx_motion, input dy_motion,
                    input button_state, output ready);
endinterface

// File: rtl/core/ps2_mouse_packet_decoder.sv
// ============================================================================
// PS/2 mouse three-byte packet decoder
// Assembles header, X and Y bytes into one motion/button packet.
// ============================================================================
//
//  channel       dir  beat payload                         beats
//  -----------   ---  -------------------------------      ---------------------
//  mouse_bytes   in   data_byte[7:0]                       one per mouse byte
//  packets       out  dx_motion[8:0] dy_motion[9:0]        one per three-byte
//                     button_state[2:0]                    packet
//
//  Path: a byte is registered at acceptance and decoded from the byte
//  register; a Y byte waits there for a free result register, and its
//  packet then shows on packets from the result register.
//  Rate: one byte per cycle while no packet is held; the byte register and
//  the result register each free up in the same cycle they hand off.
//  Stalls: only a Y byte waiting on a held result blocks the byte register;
//  header and X bytes always move on.
//  Reset: rst_n clears the valid flags and the phase (awaiting header).
//
module ps2_mouse_packet_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    ps2mpd_byte_if.sink          mouse_bytes,
    ps2mpd_pkt_if.source         packets
);
    import ps2mpd_pkg::*;

    // Byte register
    logic   byte_valid_reg;
    byte_t  byte_reg;

    // Decode state
    phase_t phase_reg;
    phase_t phase_next;
    byte_t  header_reg;
    byte_t  xbyte_reg;

    // Result register
    logic   out_valid_reg;
    delta_t dx_reg;
    dy_t    dy_reg;
    btn_t   btn_reg;

    logic   out_free;
    logic   fire;
    logic   makes_result;
    logic   load_header;
    logic   load_xbyte;
    delta_t dx_calc;
    delta_t ynat_calc;
    dy_t    dy_calc;

    assign out_free = !out_valid_reg || packets.ready;

    // Outputs of the phase machine for the byte sitting in the register
    always_comb
    begin
        makes_result = 1'b0;
        load_header  = 1'b0;
        load_xbyte   = 1'b0;
        unique case (phase_reg)
            PH_XBYTE:
            begin
                load_xbyte = 1'b1;
            end
            PH_YBYTE:
            begin
                makes_result = 1'b1;
            end
            default:
            begin
                load_header = byte_reg[HdrSync];
            end
        endcase
    end

    // Only a result-producing byte waits for the output slot
    assign fire              = byte_valid_reg && (!makes_result || out_free);
    assign mouse_bytes.ready = !byte_valid_reg || fire;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_XBYTE: phase_next = PH_YBYTE;
                PH_YBYTE: phase_next = PH_HEADER;
                default:  phase_next = byte_reg[HdrSync] ? PH_XBYTE : PH_HEADER;
            endcase
        end
    end

    // Packet arithmetic; Y is negated into screen direction
    always_comb
    begin
        dx_calc   = make_delta(xbyte_reg, header_reg[HdrXSign], header_reg[HdrXOvf]);
        ynat_calc = make_delta(byte_reg, header_reg[HdrYSign], header_reg[HdrYOvf]);
        dy_calc   = -dy_t'(ynat_calc);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_HEADER;
        end
        else
        begin
            if (mouse_bytes.ready)
            begin
                byte_valid_reg <= mouse_bytes.valid;
            end
            if (fire && makes_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (packets.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            phase_reg <= phase_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (mouse_bytes.valid && mouse_bytes.ready)
        begin
            byte_reg <= mouse_bytes.data_byte;
        end
        if (fire && load_header)
        begin
            header_reg <= byte_reg;
        end
        if (fire && load_xbyte)
        begin
            xbyte_reg <= byte_reg;
        end
        if (fire && makes_result)
        begin
            dx_reg  <= dx_calc;
            dy_reg  <= dy_calc;
            btn_reg <= header_reg[HdrBtnMsb:0];
        end
    end

    assign packets.valid        = out_valid_reg;
    assign packets.dx_motion    = dx_reg;
    assign packets.dy_motion    = dy_reg;
    assign packets.button_state = btn_reg;

endmodule

// File: rtl/core/ps2mpd_checker.sv
// ============================================================================
// PS/2 mouse packet decoder checker
// Port-level assertions, bound to the decoder top level.
// ============================================================================
module ps2mpd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  ps2mpd_pkg::delta_t dx_motion,
    input  ps2mpd_pkg::dy_t    dy_motion,
    input  ps2mpd_pkg::btn_t   button_state
);
    import ps2mpd_pkg::*;

    // A held packet stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("packet dropped while stalled");

    // A held packet keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(dx_motion) && $stable(dy_motion)
            && $stable(button_state))
        else $error("packet payload changed while stalled");

    // Negated Y never leaves -255..256
    a_dy_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(dy_motion) >= -10'sd255) && ($signed(dy_motion) <= 10'sd256))
        else $error("dy_motion out of range");

    // A fresh packet follows an accepted byte beat
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("packet without a recent byte beat");

endmodule

bind ps2_mouse_packet_decoder ps2mpd_checker u_ps2mpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (mouse_bytes.valid),
    .in_ready     (mouse_bytes.ready),
    .out_valid    (packets.valid),
    .out_ready    (packets.ready),
    .dx_motion    (packets.dx_motion),
    .dy_motion    (packets.dy_motion),
    .button_state (packets.button_state)
);

// File: sim/tb_ps2_mouse_packet_decoder.sv
// ============================================================================
// PS/2 mouse packet decoder testbench
// Feeds mouse bytes through valid/ready, predicts packets, checks each beat.
// ============================================================================
//
//  Stimulus starts with a short table of bytes. Rows whose packet is obvious
//  carry the expected packet typed in. The other rows go through the packet
//  predictor. A random part follows: mostly well-formed three-byte packets
//  with random content, and some loose noise bytes that knock the stream out
//  of alignment. Both channels idle at random, in short and long gaps, with
//  calm stretches between them.
//
module tb_ps2_mouse_packet_decoder;

    import ps2mpd_pkg::*;

    // One decoded packet, as seen on the packets channel
    typedef struct {
        delta_t dx;
        dy_t    dy;
        btn_t   btn;
    } motion_pkt_t;

    // One row of the directed table
    typedef struct {
        byte_t       b;
        bit          typed;
        motion_pkt_t pkt;
    } stim_row_t;

    localparam int RandomBytes = 1200;

    logic clk;
    logic rst_n;

    ps2mpd_byte_if byte_ch ();
    ps2mpd_pkt_if  pkt_ch ();

    ps2_mouse_packet_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .mouse_bytes (byte_ch),
        .packets     (pkt_ch)
    );

    // Predictor state: phase of the packet and the bytes captured so far
    phase_t rx_phase;
    byte_t  held_hdr;
    byte_t  held_x;

    motion_pkt_t pending_pkts[$];
    stim_row_t   stim_table[$];

    int errors;
    int live_bytes;
    int src_calm;
    int sink_calm;
    int sink_hold;

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Idle gap length: mostly none, often short, sometimes long. A calm
    // stretch forces a run of back-to-back beats.
    // ------------------------------------------------------------------------
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // ------------------------------------------------------------------------
    // Motion value from a data byte: the header sign bit extends it to nine
    // bits, the overflow bit pins it to +-255. Zero with overflow goes to
    // +255 since zero counts as non-negative.
    // ------------------------------------------------------------------------
    function automatic int signed_motion(input byte_t raw, input logic neg,
                                         input logic ovf);
        int v;
        v = int'(raw);
        if (neg)
            v = v - 256;
        if (ovf)
            v = (v < 0) ? -255 : 255;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Packet predictor: advances the phase on one byte, returns 1 and the
    // packet when the byte closes a packet.
    // ------------------------------------------------------------------------
    function automatic bit decode_mouse_byte(input byte_t b, output motion_pkt_t p);
        p.dx  = '0;
        p.dy  = '0;
        p.btn = '0;
        case (rx_phase)
            PH_XBYTE:
            begin
                held_x   = b;
                rx_phase = PH_YBYTE;
                return 1'b0;
            end
            PH_YBYTE:
            begin
                p.dx  = delta_t'(signed_motion(held_x, held_hdr[HdrXSign],
                                               held_hdr[HdrXOvf]));
                // Y flips to screen direction after the clamp
                p.dy  = dy_t'(-signed_motion(b, held_hdr[HdrYSign],
                                             held_hdr[HdrYOvf]));
                p.btn = held_hdr[HdrBtnMsb:0];
                rx_phase = PH_HEADER;
                return 1'b1;
            end
            default:
            begin
                // Resync: anything without the sync bit is not a header
                rx_phase = PH_HEADER;
                if (b[HdrSync])
                begin
                    held_hdr = b;
                    rx_phase = PH_XBYTE;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void add_row(input byte_t b, input bit typed,
                                    input int dx, input int dy, input int btn);
        stim_row_t row;
        row.b       = b;
        row.typed   = typed;
        row.pkt.dx  = delta_t'(dx);
        row.pkt.dy  = dy_t'(dy);
        row.pkt.btn = btn_t'(btn);
        stim_table.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Byte source. Called at a rising edge; returns at the edge where the
    // beat is taken. Valid gets one assignment per time step.
    // ------------------------------------------------------------------------
    task automatic send_byte(input byte_t b);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
    endtask

    // Predict first, so the expectation is queued long before the packet
    task automatic feed_byte(input byte_t b, input bit typed,
                             input motion_pkt_t typed_pkt);
        motion_pkt_t p;
        if (!(rx_phase == PH_HEADER && !b[HdrSync]))
            live_bytes++;
        if (decode_mouse_byte(b, p))
            pending_pkts.push_back(typed ? typed_pkt : p);
        send_byte(b);
    endtask

    // ------------------------------------------------------------------------
    // Packet sink: compares each accepted beat with the oldest expectation
    // and drives ready with random stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        motion_pkt_t exp_pkt;
        bit          took;
        took = 1'b0;
        if (!rst_n)
        begin
            pkt_ch.ready <= 1'b0;
        end
        else
        begin
            if (pkt_ch.valid && pkt_ch.ready)
            begin
                took = 1'b1;
                if (pending_pkts.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected packet: dx=%0d dy=%0d btn=%0d",
                                 pkt_ch.dx_motion, pkt_ch.dy_motion,
                                 pkt_ch.button_state);
                    errors++;
                end
                else
                begin
                    exp_pkt = pending_pkts.pop_front();
                    if (pkt_ch.dx_motion !== exp_pkt.dx ||
                        pkt_ch.dy_motion !== exp_pkt.dy ||
                        pkt_ch.button_state !== exp_pkt.btn)
                    begin
                        if (errors < 10)
                            $display(
                                "packet mismatch: exp dx/dy/btn=%0d/%0d/%0d, got %0d/%0d/%0d",
                                exp_pkt.dx, exp_pkt.dy, exp_pkt.btn,
                                pkt_ch.dx_motion, pkt_ch.dy_motion,
                                pkt_ch.button_state);
                        errors++;
                    end
                end
            end
            // Stall after a beat, and now and then out of the blue
            if (took || $urandom_range(0, 19) == 0)
                sink_hold = pick_gap(sink_calm);
            if (sink_hold > 0)
            begin
                sink_hold--;
                pkt_ch.ready <= 1'b0;
            end
            else
            begin
                pkt_ch.ready <= 1'b1;
            end
        end
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #2000000;
        $display("ps2_mouse_packet_decoder test failed");
        $finish;
    end

    initial
    begin
        motion_pkt_t none;
        int          choice;
        int          rand_x;
        int          rand_y;

        clk               = 1'b0;
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        pkt_ch.ready      = 1'b0;
        rx_phase          = PH_HEADER;
        held_hdr          = '0;
        held_x            = '0;
        errors            = 0;
        live_bytes        = 0;
        src_calm          = 0;
        sink_calm         = 0;
        sink_hold         = 0;
        none.dx           = '0;
        none.dy           = '0;
        none.btn          = '0;

        // Directed table. Typed packets are the ones readable at a glance.
        // Headers without the sync bit are dropped, even with every other bit set
        add_row(8'h00, 1'b0, 0, 0, 0);
        add_row(8'hF7, 1'b0, 0, 0, 0);
        // Plain zero packet
        add_row(8'h08, 1'b0, 0, 0, 0);
        add_row(8'h00, 1'b0, 0, 0, 0);
        add_row(8'h00, 1'b1, 0, 0, 0);
        // All header bits: both signs, both overflows, all buttons
        add_row(8'hFF, 1'b0, 0, 0, 0);
        add_row(8'h00, 1'b0, 0, 0, 0);
        add_row(8'h00, 1'b1, -255, 255, 7);
        // Overflow on a zero delta clamps to the positive side
        add_row(8'hC8, 1'b0, 0, 0, 0);
        add_row(8'h00, 1'b0, 0, 0, 0);
        add_row(8'h00, 1'b1, 255, -255, 0);
        // Most negative X, largest downward Y
        add_row(8'h38, 1'b0, 0, 0, 0);
        add_row(8'h00, 1'b0, 0, 0, 0);
        add_row(8'h00, 1'b1, -256, 256, 0);
        // Most positive X, most upward Y
        add_row(8'h08, 1'b0, 0, 0, 0);
        add_row(8'hFF, 1'b0, 0, 0, 0);
        add_row(8'hFF, 1'b1, 255, -255, 0);
        // Minus one on both axes
        add_row(8'h3F, 1'b0, 0, 0, 0);
        add_row(8'hFF, 1'b0, 0, 0, 0);
        add_row(8'hFF, 1'b1, -1, 1, 7);
        // Mid-range values, left to the predictor
        add_row(8'h09, 1'b0, 0, 0, 0);
        add_row(8'h80, 1'b0, 0, 0, 0);
        add_row(8'h7F, 1'b0, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            feed_byte(stim_table[i].b, stim_table[i].typed, stim_table[i].pkt);

        // Random part: mostly whole packets, some noise bytes
        live_bytes = 0;
        while (live_bytes < RandomBytes)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 85)
            begin
                // Zero deltas now and then, to hit overflow on zero
                rand_x = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255);
                rand_y = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255);
                feed_byte(byte_t'($urandom_range(0, 255)) | byte_t'(1 << HdrSync),
                          1'b0, none);
                feed_byte(byte_t'(rand_x), 1'b0, none);
                feed_byte(byte_t'(rand_y), 1'b0, none);
            end
            else
            begin
                feed_byte(byte_t'($urandom_range(0, 255)), 1'b0, none);
            end
        end
        byte_ch.valid <= 1'b0;

        // Drain, then give a stray packet time to show
        while (pending_pkts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("ps2_mouse_packet_decoder test passed");
        else
            $display("ps2_mouse_packet_decoder test failed");
        $finish;
    end

endmodule
